// ----- hdl/tmag_pkg.sv -----
// Shared constants for the tone-map accumulate block.
`default_nettype none
package tmag_pkg;

    localparam int SCREEN_W_DEF = 1024;
    localparam int SCREEN_H_DEF = 1024;

    localparam int CNT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int WORD_W = CNT_W + 3 * SUM_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] LUM_R = 16'd13933;
    localparam logic [15:0] LUM_G = 16'd46871;
    localparam logic [15:0] LUM_B = 16'd4732;
    localparam logic [23:0] CUBE_255 = 24'd16581375;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [15:0] LUM_ROUND = 16'h8000;
    localparam logic [15:0] EXPOSURE_RESET = 16'd256;
    localparam logic [7:0]  BYTE_MAX = 8'hFF;

    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [4:0] TONE_DIV_STEPS = 5'd16;
    localparam logic [4:0] AVG_DIV_STEPS  = 5'd17;

endpackage
`default_nettype wire

// ----- hdl/tmag_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tmag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/tonemap_accumulate_gamma_pixel.sv -----
// Extended Reinhard luminance tone map with per-pixel accumulation and gamma output.
//
// A sample (cmd 0) keeps busy high while it runs; one 32x32 multiplier
// and one restoring divider that retires a quotient bit per cycle are shared
// by the luminance sum, tone curve, averaging and the 8-step gamma search.
// done pulses for one cycle with out_x, out_y and pixel_rgb; the receiver
// cannot stall, so take the result in that cycle. A sample off screen gives
// no result and busy stays low. A clear (cmd 1) sweeps the pixel memory one
// entry a cycle, SCREEN_W*SCREEN_H entries in all, and the same sweep runs after
// reset; busy is high throughout. exposure may be written at any time the
// block is idle.
`default_nettype none
module tonemap_accumulate_gamma_pixel #(
    parameter int SCREEN_W = tmag_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = tmag_pkg::SCREEN_H_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    input  logic [23:0] color_red,
    input  logic [23:0] color_green,
    input  logic [23:0] color_blue,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        done,
    output logic [9:0]  out_x,
    output logic [9:0]  out_y,
    output logic [23:0] pixel_rgb
);

    localparam int DEPTH = SCREEN_W * SCREEN_H;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW = tmag_pkg::WORD_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_LUM   = 8'b0000_0100,
        S_TONE  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_AVG   = 8'b0100_0000,
        S_GAM   = 8'b1000_0000
    } state_t;

    state_t      state_reg;
    logic [2:0]  st_reg;
    logic [1:0]  ch_reg;
    logic [4:0]  dcnt_reg;
    logic [2:0]  kb_reg;
    logic [7:0]  k_reg;
    logic        div_avg_reg;
    logic [15:0] exposure_reg;
    logic [9:0]  x_reg;
    logic [9:0]  y_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [23:0] color_reg [3];
    logic [31:0] e2_reg;
    logic [23:0] lq_reg;
    logic [56:0] acc_reg;
    logic [56:0] d_reg;
    logic [63:0] prod_reg;
    logic [56:0] rem_reg;
    logic [56:0] den_reg;
    logic [16:0] dsh_reg;
    logic [16:0] q_reg;
    logic [16:0] tone_reg [3];
    logic [31:0] sum_reg [3];
    logic [15:0] cnt_reg;
    logic [16:0] avg_reg;
    logic [55:0] rhs_reg;
    logic [7:0]  byte_reg [2];
    logic        done_reg;
    logic [9:0]  out_x_reg;
    logic [9:0]  out_y_reg;
    logic [23:0] pixel_rgb_reg;

    logic [15:0] e_eff;
    logic [23:0] c_sel;
    logic [7:0]  cand;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [57:0] n_sum;
    logic [57:0] rem_sh;
    logic [57:0] rem_sub;
    logic        div_ge;
    logic [16:0] q_step;
    logic        kc_ok;
    logic        in_screen;
    logic [AW-1:0] idx_in;
    logic        tone_fin;
    logic [16:0] tone_val;
    logic        gam_fin;
    logic [7:0]  gam_byte;
    logic [WW-1:0] rdata;
    logic [WW-1:0] wdata;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0] cnt_old;
    logic        cnt_full;
    logic [31:0] sum_old [3];
    logic [31:0] sum_new [3];

    assign e_eff = (exposure_reg == 16'd0) ? 16'd1 : exposure_reg;
    assign c_sel = color_reg[ch_reg];
    assign cand  = k_reg | (8'd1 << kb_reg);

    assign in_screen = ({22'd0, pixel_x} < 32'(SCREEN_W)) && ({22'd0, pixel_y} < 32'(SCREEN_H));
    assign idx_in    = AW'({22'd0, pixel_x} + {22'd0, pixel_y} * 32'(SCREEN_W));

    // shared multiplier operand select; product is registered every cycle
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_LUM:
            begin
                case (st_reg)
                    3'd0:
                    begin
                        mul_a = {16'd0, e_eff};
                        mul_b = {16'd0, e_eff};
                    end
                    3'd1:
                    begin
                        mul_a = {8'd0, color_reg[0]};
                        mul_b = {16'd0, tmag_pkg::LUM_R};
                    end
                    3'd2:
                    begin
                        mul_a = {8'd0, color_reg[1]};
                        mul_b = {16'd0, tmag_pkg::LUM_G};
                    end
                    3'd3:
                    begin
                        mul_a = {8'd0, color_reg[2]};
                        mul_b = {16'd0, tmag_pkg::LUM_B};
                    end
                    default:
                    begin
                        mul_a = 32'd0;
                    end
                endcase
            end
            S_TONE:
            begin
                case (st_reg)
                    3'd0:
                    begin
                        mul_a = e2_reg;
                        mul_b = {8'd0, lq_reg};
                    end
                    3'd1:
                    begin
                        mul_a = {8'd0, c_sel};
                        mul_b = e2_reg;
                    end
                    3'd2:
                    begin
                        mul_a = {8'd0, c_sel};
                        mul_b = {8'd0, lq_reg};
                    end
                    default:
                    begin
                        mul_a = 32'd0;
                    end
                endcase
            end
            S_GAM:
            begin
                case (st_reg)
                    3'd0:
                    begin
                        mul_a = {16'd0, avg_reg[15:0]};
                        mul_b = {16'd0, avg_reg[15:0]};
                    end
                    3'd1:
                    begin
                        mul_a = prod_reg[31:0];
                        mul_b = {8'd0, tmag_pkg::CUBE_255};
                    end
                    3'd3:
                    begin
                        mul_a = {24'd0, cand};
                        mul_b = {24'd0, cand};
                    end
                    3'd4:
                    begin
                        mul_a = {16'd0, prod_reg[15:0]};
                        mul_b = {24'd0, cand};
                    end
                    default:
                    begin
                        mul_a = 32'd0;
                    end
                endcase
            end
            S_IDLE, S_CLEAR, S_DIV, S_UPD, S_AVG:
            begin
                mul_a = 32'd0;
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    assign n_sum   = {1'b0, acc_reg} + {1'b0, prod_reg[56:0]};
    assign rem_sh  = {rem_reg, dsh_reg[16]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign q_step  = {q_reg[15:0], div_ge};
    // k^3 * 2^32 <= a^2 * 255^3
    assign kc_ok   = {prod_reg[23:0], 32'd0} <= rhs_reg;

    assign tone_fin = ((state_reg == S_TONE) && (st_reg == 3'd3) && (n_sum >= {1'b0, d_reg}))
                   || ((state_reg == S_DIV) && (dcnt_reg == 5'd1) && !div_avg_reg);
    assign tone_val = (state_reg == S_TONE) ? tmag_pkg::ONE_Q16 : q_step;

    assign gam_fin  = (state_reg == S_GAM)
                   && (((st_reg == 3'd0) && avg_reg[16]) || ((st_reg == 3'd5) && (kb_reg == 3'd0)));
    assign gam_byte = (st_reg == 3'd0) ? tmag_pkg::BYTE_MAX : (kc_ok ? cand : k_reg);

    // memory word: count, blue, green, red
    assign cnt_old    = rdata[WW-1 -: 16];
    assign sum_old[0] = rdata[31:0];
    assign sum_old[1] = rdata[63:32];
    assign sum_old[2] = rdata[95:64];
    assign cnt_full   = cnt_old == tmag_pkg::COUNT_MAX;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_new[i] = sum_old[i] + {15'd0, tone_reg[i]};
        end
    end

    assign we    = (state_reg == S_CLEAR) || ((state_reg == S_UPD) && !cnt_full);
    assign waddr = (state_reg == S_CLEAR) ? clr_addr_reg : idx_reg;
    assign wdata = (state_reg == S_CLEAR) ? '0
                 : {cnt_old + 16'd1, sum_new[2], sum_new[1], sum_new[0]};

    tmag_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            st_reg        <= 3'd0;
            ch_reg        <= 2'd0;
            dcnt_reg      <= 5'd0;
            kb_reg        <= 3'd0;
            k_reg         <= 8'd0;
            div_avg_reg   <= 1'b0;
            exposure_reg  <= tmag_pkg::EXPOSURE_RESET;
            x_reg         <= 10'd0;
            y_reg         <= 10'd0;
            idx_reg       <= '0;
            clr_addr_reg  <= '0;
            e2_reg        <= 32'd0;
            lq_reg        <= 24'd0;
            acc_reg       <= 57'd0;
            d_reg         <= 57'd0;
            prod_reg      <= 64'd0;
            rem_reg       <= 57'd0;
            den_reg       <= 57'd0;
            dsh_reg       <= 17'd0;
            q_reg         <= 17'd0;
            cnt_reg       <= 16'd0;
            avg_reg       <= 17'd0;
            rhs_reg       <= 56'd0;
            done_reg      <= 1'b0;
            out_x_reg     <= 10'd0;
            out_y_reg     <= 10'd0;
            pixel_rgb_reg <= 24'd0;
            for (int i = 0; i < 3; i++)
            begin
                color_reg[i] <= 24'd0;
                tone_reg[i]  <= 17'd0;
                sum_reg[i]   <= 32'd0;
            end
            byte_reg[0] <= 8'd0;
            byte_reg[1] <= 8'd0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                exposure_reg <= cfg_wdata;
            end

            if (tone_fin)
            begin
                tone_reg[ch_reg] <= tone_val;
                st_reg <= 3'd0;
                if (ch_reg == 2'd2)
                begin
                    ch_reg    <= 2'd0;
                    state_reg <= S_UPD;
                end
                else
                begin
                    ch_reg    <= ch_reg + 2'd1;
                    state_reg <= S_TONE;
                end
            end
            else if (gam_fin)
            begin
                if (ch_reg == 2'd2)
                begin
                    out_x_reg     <= x_reg;
                    out_y_reg     <= y_reg;
                    pixel_rgb_reg <= {byte_reg[0], byte_reg[1], gam_byte};
                    done_reg      <= 1'b1;
                    ch_reg        <= 2'd0;
                    state_reg     <= S_IDLE;
                end
                else
                begin
                    byte_reg[ch_reg[0]] <= gam_byte;
                    ch_reg    <= ch_reg + 2'd1;
                    state_reg <= S_AVG;
                end
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (start)
                        begin
                            if (cmd == tmag_pkg::CMD_CLEAR)
                            begin
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            else if (in_screen)
                            begin
                                x_reg        <= pixel_x;
                                y_reg        <= pixel_y;
                                idx_reg      <= idx_in;
                                color_reg[0] <= color_red;
                                color_reg[1] <= color_green;
                                color_reg[2] <= color_blue;
                                st_reg       <= 3'd0;
                                state_reg    <= S_LUM;
                            end
                        end
                    end
                    S_CLEAR:
                    begin
                        if (clr_addr_reg == AW'(DEPTH - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            clr_addr_reg <= clr_addr_reg + AW'(1);
                        end
                    end
                    S_LUM:
                    begin
                        st_reg <= st_reg + 3'd1;
                        case (st_reg)
                            3'd1:
                            begin
                                e2_reg <= prod_reg[31:0];
                            end
                            3'd2:
                            begin
                                acc_reg <= {16'd0, prod_reg[40:0]} + {41'd0, tmag_pkg::LUM_ROUND};
                            end
                            3'd3:
                            begin
                                acc_reg <= n_sum[56:0];
                            end
                            3'd4:
                            begin
                                lq_reg <= n_sum[39:16];
                                st_reg <= 3'd0;
                                ch_reg <= 2'd0;
                                for (int i = 0; i < 3; i++)
                                begin
                                    tone_reg[i] <= 17'd0;
                                end
                                // zero luminance: black sample
                                state_reg <= (n_sum[39:16] == 24'd0) ? S_UPD : S_TONE;
                            end
                            default:
                            begin
                                acc_reg <= acc_reg;
                            end
                        endcase
                    end
                    S_TONE:
                    begin
                        st_reg <= st_reg + 3'd1;
                        case (st_reg)
                            3'd1:
                            begin
                                d_reg <= {9'd0, e2_reg, 16'd0} + prod_reg[56:0];
                            end
                            3'd2:
                            begin
                                acc_reg <= prod_reg[56:0];
                            end
                            3'd3:
                            begin
                                // not saturated: 16 fraction bits of n/d
                                rem_reg     <= n_sum[56:0];
                                den_reg     <= d_reg;
                                dsh_reg     <= 17'd0;
                                q_reg       <= 17'd0;
                                dcnt_reg    <= tmag_pkg::TONE_DIV_STEPS;
                                div_avg_reg <= 1'b0;
                                state_reg   <= S_DIV;
                            end
                            default:
                            begin
                                acc_reg <= acc_reg;
                            end
                        endcase
                    end
                    S_DIV:
                    begin
                        rem_reg  <= div_ge ? rem_sub[56:0] : rem_sh[56:0];
                        dsh_reg  <= {dsh_reg[15:0], 1'b0};
                        q_reg    <= q_step;
                        dcnt_reg <= dcnt_reg - 5'd1;
                        if (dcnt_reg == 5'd1)
                        begin
                            avg_reg   <= q_step;
                            st_reg    <= 3'd0;
                            kb_reg    <= 3'd7;
                            k_reg     <= 8'd0;
                            state_reg <= S_GAM;
                        end
                    end
                    S_UPD:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= cnt_full ? sum_old[i] : sum_new[i];
                        end
                        cnt_reg   <= cnt_full ? cnt_old : cnt_old + 16'd1;
                        ch_reg    <= 2'd0;
                        state_reg <= S_AVG;
                    end
                    S_AVG:
                    begin
                        // quotient fits 17 bits, so the top 15 dividend bits seed the remainder
                        rem_reg     <= {42'd0, sum_reg[ch_reg][31:17]};
                        dsh_reg     <= sum_reg[ch_reg][16:0];
                        den_reg     <= {41'd0, cnt_reg};
                        q_reg       <= 17'd0;
                        dcnt_reg    <= tmag_pkg::AVG_DIV_STEPS;
                        div_avg_reg <= 1'b1;
                        state_reg   <= S_DIV;
                    end
                    S_GAM:
                    begin
                        st_reg <= st_reg + 3'd1;
                        case (st_reg)
                            3'd2:
                            begin
                                rhs_reg <= prod_reg[55:0];
                            end
                            3'd5:
                            begin
                                // binary search for the largest byte, MSB first
                                k_reg  <= gam_byte;
                                kb_reg <= kb_reg - 3'd1;
                                st_reg <= 3'd3;
                            end
                            default:
                            begin
                                rhs_reg <= rhs_reg;
                            end
                        endcase
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign pixel_rgb = pixel_rgb_reg;

endmodule
`default_nettype wire

// ----- hdl/tmag_chk.sv -----
// Port-level checks for the tone-map accumulate block, bound to the top level.
`default_nettype none
module tmag_chk (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        cmd,
    input wire        done
);

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding busy");

    // the block is idle again when its result shows
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    // a clear always starts the memory sweep
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd) |=> (busy && !done))
        else $error("clear did not start");

endmodule

bind tonemap_accumulate_gamma_pixel tmag_chk u_tmag_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);
`default_nettype wire

// ----- test/tonemap_accumulate_gamma_pixel_test.sv -----
// Testbench for tonemap_accumulate_gamma_pixel: random samples checked against a local predictor.
`timescale 1ns / 100ps
module tonemap_accumulate_gamma_pixel_test;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [23:0] red;
        logic [23:0] green;
        logic [23:0] blue;
    } sample_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [23:0] rgb;
    } plot_t;

    localparam int CYCLE_LIMIT = 12_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [23:0] color_red;
    logic [23:0] color_green;
    logic [23:0] color_blue;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        done;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic [23:0] pixel_rgb;

    sample_t     pending_samples[$];
    plot_t       expected_plots[$];
    logic [31:0] acc_red[int];
    logic [31:0] acc_green[int];
    logic [31:0] acc_blue[int];
    logic [15:0] acc_count[int];
    logic [15:0] exposure_q;
    bit          bursty;
    int          gap_left;
    int          errors;
    int          cycles;

    tonemap_accumulate_gamma_pixel u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .color_red(color_red),
        .color_green(color_green), .color_blue(color_blue),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
        .out_x(out_x), .out_y(out_y), .pixel_rgb(pixel_rgb)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [16:0] tone_channel(logic [23:0] c, logic [31:0] e2,
                                                 logic [23:0] lq);
        logic [127:0] n;
        logic [127:0] d;
        n = 128'(c) * (128'(e2) + 128'(lq));
        d = 128'(e2) * (128'(tmag_pkg::ONE_Q16) + 128'(lq));
        if (n >= d)
            return tmag_pkg::ONE_Q16;
        return 17'((n << 16) / d);
    endfunction

    // largest k with (k/255)^3 <= (a/2^16)^2
    function automatic logic [7:0] gamma_byte(logic [31:0] a);
        logic [127:0] rhs;
        logic [127:0] kc;
        rhs = 128'(a) * 128'(a) * 128'(tmag_pkg::CUBE_255);
        for (int k = 255; k > 0; k--)
        begin
            kc = 128'(k) * 128'(k) * 128'(k);
            if ((kc << 32) <= rhs)
                return 8'(k);
        end
        return 8'd0;
    endfunction

    function automatic plot_t accumulate_sample(sample_t s);
        plot_t       p;
        int          idx;
        logic [63:0] lsum;
        logic [23:0] lq;
        logic [31:0] e;
        logic [31:0] e2;
        logic [16:0] tr;
        logic [16:0] tg;
        logic [16:0] tb;
        logic [15:0] cnt;
        idx = int'(s.x) + int'(s.y) * tmag_pkg::SCREEN_W_DEF;
        lsum = 64'(tmag_pkg::LUM_R) * s.red + 64'(tmag_pkg::LUM_G) * s.green
               + 64'(tmag_pkg::LUM_B) * s.blue + 64'(tmag_pkg::LUM_ROUND);
        lq = 24'(lsum >> 16);
        e = (exposure_q == 16'd0) ? 32'd1 : 32'(exposure_q);
        e2 = e * e;
        tr = '0;
        tg = '0;
        tb = '0;
        if (lq != 0)
        begin
            tr = tone_channel(s.red, e2, lq);
            tg = tone_channel(s.green, e2, lq);
            tb = tone_channel(s.blue, e2, lq);
        end
        if (!acc_count.exists(idx))
        begin
            acc_count[idx] = '0;
            acc_red[idx] = '0;
            acc_green[idx] = '0;
            acc_blue[idx] = '0;
        end
        cnt = acc_count[idx];
        if (cnt < tmag_pkg::COUNT_MAX)
        begin
            acc_red[idx] += 32'(tr);
            acc_green[idx] += 32'(tg);
            acc_blue[idx] += 32'(tb);
            cnt++;
            acc_count[idx] = cnt;
        end
        p.x = s.x;
        p.y = s.y;
        p.rgb = {gamma_byte(acc_red[idx] / cnt), gamma_byte(acc_green[idx] / cnt),
                 gamma_byte(acc_blue[idx] / cnt)};
        return p;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= 1'b0;
            pixel_x <= '0;
            pixel_y <= '0;
            color_red <= '0;
            color_green <= '0;
            color_blue <= '0;
            gap_left = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                if (cmd == tmag_pkg::CMD_CLEAR)
                begin
                    acc_red.delete();
                    acc_green.delete();
                    acc_blue.delete();
                    acc_count.delete();
                end
                else
                    expected_plots.push_back(accumulate_sample(
                        {cmd, pixel_x, pixel_y, color_red, color_green, color_blue}));
                if (bursty && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 40);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                nxt = pending_samples.pop_front();
                start <= 1'b1;
                cmd <= nxt.cmd;
                pixel_x <= nxt.x;
                pixel_y <= nxt.y;
                color_red <= nxt.red;
                color_green <= nxt.green;
                color_blue <= nxt.blue;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        plot_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** tonemap_accumulate_gamma_pixel: FAILED **");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_plots.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d rgb=%h", $time,
                         out_x, out_y, pixel_rgb);
                errors++;
            end
            else
            begin
                want = expected_plots.pop_front();
                if (out_x !== want.x)
                begin
                    $display("%0t: out_x expected %0d got %0d", $time, want.x, out_x);
                    errors++;
                end
                if (out_y !== want.y)
                begin
                    $display("%0t: out_y expected %0d got %0d", $time, want.y, out_y);
                    errors++;
                end
                if (pixel_rgb !== want.rgb)
                begin
                    $display("%0t: pixel_rgb expected %h got %h", $time, want.rgb, pixel_rgb);
                    errors++;
                end
            end
        end
    end

    function automatic logic [23:0] rand_color();
        case ($urandom_range(0, 5))
            0: return 24'($urandom());
            1: return 24'($urandom_range(0, 16));
            2: return 24'($urandom_range(0, 32'h1_0000));
            3: return 24'hFFFFFF - 24'($urandom_range(0, 255));
            4: return 24'($urandom_range(0, 32'h4_0000));
            default: return '0;
        endcase
    endfunction

    task automatic push_sample(logic [9:0] x, logic [9:0] y, logic [23:0] r,
                               logic [23:0] g, logic [23:0] b);
        sample_t s;
        s = {1'b0, x, y, r, g, b};
        pending_samples.push_back(s);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_samples.size() > 0 || start || busy || expected_plots.size() > 0);
        repeat (250) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_exposure(logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        exposure_q = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] phase_exposure[6];
        sample_t     noise;
        errors = 0;
        cycles = 0;
        bursty = 1'b0;
        exposure_q = tmag_pkg::EXPOSURE_RESET;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed: field extremes, zero and near-zero luminance, repeats, clear
        push_sample(10'd0, 10'd0, 24'd0, 24'd0, 24'd0);
        push_sample(10'd1023, 10'd1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_sample(10'd1023, 10'd0, 24'hFFFFFF, 24'd0, 24'd0);
        push_sample(10'd0, 10'd1023, 24'd0, 24'hFFFFFF, 24'd0);
        push_sample(10'd5, 10'd5, 24'd0, 24'd0, 24'hFFFFFF);
        push_sample(10'd5, 10'd5, 24'd1, 24'd0, 24'd0);
        push_sample(10'd5, 10'd5, 24'h010000, 24'h010000, 24'h010000);
        push_sample(10'd5, 10'd5, 24'h008000, 24'h004000, 24'h00C000);
        push_sample(10'd0, 10'd0, 24'h010000, 24'h010000, 24'h010000);
        push_sample(10'd0, 10'd0, 24'hFFFFFF, 24'h000001, 24'h800000);
        push_sample(10'h2AA, 10'h155, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        push_sample(10'h155, 10'h2AA, 24'h555555, 24'hAAAAAA, 24'h555555);
        noise = '0;
        noise.cmd = tmag_pkg::CMD_CLEAR;
        noise.x = 10'h3FF;
        noise.red = 24'hFFFFFF;
        pending_samples.push_back(noise);
        push_sample(10'd5, 10'd5, 24'h020000, 24'h010000, 24'h000100);
        push_sample(10'd1023, 10'd1023, 24'h000100, 24'h000100, 24'h000100);
        wait_idle();

        phase_exposure[0] = 16'd0;
        phase_exposure[1] = 16'd1;
        phase_exposure[2] = 16'hFFFF;
        phase_exposure[3] = tmag_pkg::EXPOSURE_RESET;
        phase_exposure[4] = 16'($urandom_range(1, 16'hFFFF));
        phase_exposure[5] = 16'($urandom_range(16, 1024));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_exposure(phase_exposure[ph]);
            bursty = (ph % 3) != 1;
            for (int i = 0; i < 320; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_sample(10'($urandom()), 10'($urandom()), rand_color(),
                                rand_color(), rand_color());
                else
                    // hammer a few pixels so the running sums grow
                    push_sample(10'($urandom_range(0, 3)), 10'($urandom_range(0, 2)),
                                rand_color(), rand_color(), rand_color());
            end
            if (ph == 3)
            begin
                noise = '0;
                noise.cmd = tmag_pkg::CMD_CLEAR;
                pending_samples.push_back(noise);
                push_sample(10'd1, 10'd1, rand_color(), rand_color(), rand_color());
            end
            wait_idle();
        end

        if (errors == 0)
            $display("** tonemap_accumulate_gamma_pixel: PASSED **");
        else
            $display("** tonemap_accumulate_gamma_pixel: FAILED **");
        $finish;
    end
endmodule
